@@ rtl/core/png_unf_pkg.sv @@
// Shared types and constants for the PNG scanline unfilter core.
package png_unf_pkg;

    localparam int DEF_MAX_ROW_BYTES   = 4096;
    localparam int DEF_MAX_PIXEL_BYTES = 8;

    localparam int ROW_BYTES_W   = 13;
    localparam int PIXEL_BYTES_W = 4;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_INDEX_W   = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_BYTES   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_BYTES = 1'b1;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } filter_t;

    // One data word handed from the front part to the back part.
    typedef struct packed {
        logic [7:0] data;
        filter_t    filter;
        logic       first_row;
        logic       row_first;
        logic       last;
    } item_t;

endpackage

@@ rtl/core/png_unf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module png_unf_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/png_unf_fifo.sv @@
// Two-entry queue used between the front and back parts and at the result side.
module png_unf_fifo
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ rtl/core/png_unf_front.sv @@
// Front part: tracks row position, takes filter codes and issues data words.
module png_unf_front
    import png_unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [7:0]                       data_byte,
    input  logic                             image_start,
    input  logic [ROW_BYTES_W-1:0]           row_bytes,
    output logic                             q_push,
    output item_t                            q_item,
    output logic [$clog2(MAX_ROW_BYTES)-1:0] q_col
);

    localparam int CW = $clog2(MAX_ROW_BYTES + 1);
    localparam int AW = $clog2(MAX_ROW_BYTES);

    logic          awaiting_reg;
    logic          awaiting_next;
    logic          first_row_reg;
    logic          first_row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    filter_t       filter_reg;
    filter_t       filter_next;

    logic          awaiting;
    logic          first_row;
    logic [CW-1:0] col;
    logic [CW-1:0] row_len;
    logic          last;
    filter_t       code;

    // Clamp the row length to the supported range.
    always_comb
    begin
        if (row_bytes == '0)
        begin
            row_len = CW'(1);
        end
        else if (32'(row_bytes) > 32'(MAX_ROW_BYTES))
        begin
            row_len = CW'(MAX_ROW_BYTES);
        end
        else
        begin
            row_len = CW'(row_bytes);
        end
    end

    always_comb
    begin
        unique case (data_byte)
            8'd1:    code = FLT_SUB;
            8'd2:    code = FLT_UP;
            8'd3:    code = FLT_AVG;
            8'd4:    code = FLT_PAETH;
            default: code = FLT_NONE;
        endcase
    end

    // An image start drops any row in progress.
    assign awaiting  = awaiting_reg || image_start;
    assign first_row = first_row_reg || image_start;
    assign col       = image_start ? '0 : col_reg;
    assign last      = ({1'b0, col} + {{CW{1'b0}}, 1'b1}) >= {1'b0, row_len};

    assign q_push           = accept && !awaiting;
    assign q_item.data      = data_byte;
    assign q_item.filter    = filter_reg;
    assign q_item.first_row = first_row;
    assign q_item.row_first = (col == '0);
    assign q_item.last      = last;
    assign q_col            = col[AW-1:0];

    always_comb
    begin
        awaiting_next  = awaiting_reg;
        first_row_next = first_row_reg;
        col_next       = col_reg;
        filter_next    = filter_reg;
        if (accept)
        begin
            if (awaiting)
            begin
                filter_next    = code;
                awaiting_next  = 1'b0;
                first_row_next = first_row;
                col_next       = '0;
            end
            else if (last)
            begin
                awaiting_next  = 1'b1;
                first_row_next = 1'b0;
                col_next       = '0;
            end
            else
            begin
                first_row_next = first_row;
                col_next       = col + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_reg  <= 1'b1;
            first_row_reg <= 1'b1;
            col_reg       <= '0;
            filter_reg    <= FLT_NONE;
        end
        else
        begin
            awaiting_reg  <= awaiting_next;
            first_row_reg <= first_row_next;
            col_reg       <= col_next;
            filter_reg    <= filter_next;
        end
    end

endmodule

@@ rtl/core/png_unf_back.sv @@
// Back part: reads the line above, rebuilds each byte and updates the line store.
module png_unf_back
    import png_unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [PIXEL_BYTES_W-1:0]         bytes_per_pixel,
    input  logic                             q_valid,
    input  item_t                            q_item,
    input  logic [$clog2(MAX_ROW_BYTES)-1:0] q_col,
    output logic                             q_pop,
    input  logic                             o_full,
    output logic                             o_push,
    output logic [7:0]                       o_pixel,
    output logic                             o_row_end
);

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int PW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

    logic          s_valid_reg;
    item_t         s_item_reg;
    logic [AW-1:0] s_col_reg;
    logic          byp_valid_reg;
    logic [7:0]    byp_data_reg;
    logic [7:0]    cur_reg   [MAX_PIXEL_BYTES];
    logic [7:0]    above_reg [MAX_PIXEL_BYTES];
    logic [7:0]    cur_eff   [MAX_PIXEL_BYTES];
    logic [7:0]    above_eff [MAX_PIXEL_BYTES];

    logic          leave;
    logic          load;
    logic [7:0]    ram_q;
    logic [PW-1:0] idx;
    logic [3:0]    bpp_m1;
    logic [7:0]    a;
    logic [7:0]    b;
    logic [7:0]    c;
    logic [7:0]    pred;
    logic [7:0]    res;
    logic [8:0]    avg_sum;
    logic signed [9:0] pa;
    logic signed [9:0] pb;
    logic signed [9:0] pc;
    logic [9:0]    pa_abs;
    logic [9:0]    pb_abs;
    logic [9:0]    pc_abs;

    assign leave = s_valid_reg && !o_full;
    assign load  = q_valid && (!s_valid_reg || leave);
    assign q_pop = load;

    png_unf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line (
        .clk   (clk),
        .we    (leave),
        .waddr (s_col_reg),
        .wdata (res),
        .re    (load),
        .raddr (q_col),
        .rdata (ram_q)
    );

    // Left-neighbor tap, clamped to the supported pixel size.
    always_comb
    begin
        if (bytes_per_pixel == '0)
        begin
            bpp_m1 = 4'd0;
        end
        else if (32'(bytes_per_pixel) > 32'(MAX_PIXEL_BYTES))
        begin
            bpp_m1 = 4'(MAX_PIXEL_BYTES - 1);
        end
        else
        begin
            bpp_m1 = bytes_per_pixel - 4'd1;
        end
        idx = PW'(bpp_m1);
    end

    // A new row starts with empty left history.
    always_comb
    begin
        for (int i = 0; i < MAX_PIXEL_BYTES; i++)
        begin
            cur_eff[i]   = s_item_reg.row_first ? 8'd0 : cur_reg[i];
            above_eff[i] = s_item_reg.row_first ? 8'd0 : above_reg[i];
        end
    end

    assign a = cur_eff[idx];
    assign c = above_eff[idx];
    assign b = s_item_reg.first_row ? 8'd0 : (byp_valid_reg ? byp_data_reg : ram_q);

    assign avg_sum = {1'b0, a} + {1'b0, b};
    assign pa      = $signed({2'b00, b}) - $signed({2'b00, c});
    assign pb      = $signed({2'b00, a}) - $signed({2'b00, c});
    assign pc      = pa + pb;
    assign pa_abs  = pa[9] ? 10'(-pa) : 10'(pa);
    assign pb_abs  = pb[9] ? 10'(-pb) : 10'(pb);
    assign pc_abs  = pc[9] ? 10'(-pc) : 10'(pc);

    always_comb
    begin
        unique case (s_item_reg.filter)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = avg_sum[8:1];
            FLT_PAETH:
            begin
                if (pa_abs <= pb_abs && pa_abs <= pc_abs)
                begin
                    pred = a;
                end
                else if (pb_abs <= pc_abs)
                begin
                    pred = b;
                end
                else
                begin
                    pred = c;
                end
            end
            default:   pred = 8'd0;
        endcase
    end

    assign res       = s_item_reg.data + pred;
    assign o_push    = leave;
    assign o_pixel   = res;
    assign o_row_end = s_item_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            byp_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            begin
                cur_reg[i]   <= 8'd0;
                above_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (load)
            begin
                s_valid_reg <= 1'b1;
                // Forward the byte written in this cycle to the same column.
                byp_valid_reg <= leave && (s_col_reg == q_col);
            end
            else if (leave)
            begin
                s_valid_reg <= 1'b0;
            end
            if (leave)
            begin
                cur_reg[0]   <= res;
                above_reg[0] <= b;
                for (int i = 1; i < MAX_PIXEL_BYTES; i++)
                begin
                    cur_reg[i]   <= cur_eff[i-1];
                    above_reg[i] <= above_eff[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s_item_reg   <= q_item;
            s_col_reg    <= q_col;
            byp_data_reg <= res;
        end
    end

endmodule

@@ rtl/core/png_scanline_unfilter_core.sv @@
// PNG scanline unfilter core: takes one inflated byte per cycle while full is low
// and returns reconstructed image bytes. Sustained rate is one byte per cycle while
// the result side keeps popping; a data byte passes through the queue, the
// line-store read stage and the result queue on its way to the result ports, and
// a filter code byte gives no result.
// The previous row is held in a single-port-write, registered-read line
// store of MAX_ROW_BYTES bytes, and the reconstruction loop (left byte to
// next byte) runs combinationally through the Paeth compare. Registers:
// index 0 is row_bytes, index 1 is bytes_per_pixel; write them only while
// the core is idle.
module png_scanline_unfilter_core
    import png_unf_pkg::*;
#(
    parameter int MAX_ROW_BYTES   = DEF_MAX_ROW_BYTES,
    parameter int MAX_PIXEL_BYTES = DEF_MAX_PIXEL_BYTES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             data_byte,
    input  logic                   image_start,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             pixel_byte,
    output logic                   row_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int QW = $bits(item_t) + AW;

    logic [ROW_BYTES_W-1:0]   row_bytes_reg;
    logic [PIXEL_BYTES_W-1:0] bytes_per_pixel_reg;

    logic          accept;
    logic          q_push;
    item_t         q_item_in;
    logic [AW-1:0] q_col_in;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic [QW-1:0] q_rdata;
    item_t         q_item_out;
    logic [AW-1:0] q_col_out;
    logic          o_push;
    logic          o_full;
    logic [7:0]    o_pixel;
    logic          o_row_end;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg       <= ROW_BYTES_W'(1);
            bytes_per_pixel_reg <= PIXEL_BYTES_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROW_BYTES:   row_bytes_reg       <= cfg_data[ROW_BYTES_W-1:0];
                REG_PIXEL_BYTES: bytes_per_pixel_reg <= cfg_data[PIXEL_BYTES_W-1:0];
                default:         ;
            endcase
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    png_unf_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (data_byte),
        .image_start (image_start),
        .row_bytes   (row_bytes_reg),
        .q_push      (q_push),
        .q_item      (q_item_in),
        .q_col       (q_col_in)
    );

    png_unf_fifo #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({q_item_in, q_col_in}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign q_item_out = q_rdata[QW-1:AW];
    assign q_col_out  = q_rdata[AW-1:0];

    png_unf_back #(
        .MAX_ROW_BYTES   (MAX_ROW_BYTES),
        .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .bytes_per_pixel (bytes_per_pixel_reg),
        .q_valid         (!q_empty),
        .q_item          (q_item_out),
        .q_col           (q_col_out),
        .q_pop           (q_pop),
        .o_full          (o_full),
        .o_push          (o_push),
        .o_pixel         (o_pixel),
        .o_row_end       (o_row_end)
    );

    png_unf_fifo #(
        .WIDTH (9)
    ) u_result (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (o_push),
        .wdata ({o_pixel, o_row_end}),
        .pop   (pop),
        .rdata ({pixel_byte, row_end}),
        .full  (o_full),
        .empty (empty)
    );

    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("data word issued into a full queue");

    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back part took a word from an empty queue");

    a_result_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        o_push |-> !o_full)
        else $error("result word pushed into a full result queue");

    a_code_gives_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && image_start) |-> !q_push)
        else $error("image start byte issued as a data word");

endmodule

@@ sim/png_unfilter_checker.sv @@
// Checker for the PNG scanline unfilter core: predicts rebuilt bytes and compares results.
`timescale 1ns / 1ps

module png_unfilter_checker
    import png_unf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  logic [7:0]             data_byte,
    input  logic                   image_start,
    input  logic                   empty,
    input  logic                   pop,
    input  logic [7:0]             pixel_byte,
    input  logic                   row_end,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     expected_count
);

    typedef struct packed {
        logic [7:0] pixel;
        logic       last;
    } pixel_word_t;

    pixel_word_t expected_pixels[$];
    pixel_word_t oldest;
    int          err_count;

    // Shadow of the core state.
    logic [7:0]             prev_row [DEF_MAX_ROW_BYTES];
    logic [63:0]            left_bytes;
    logic [63:0]            upper_bytes;
    int unsigned            column;
    filter_t                row_filter;
    logic                   want_code;
    logic                   in_first_row;
    logic [ROW_BYTES_W-1:0] cfg_rows;
    logic [PIXEL_BYTES_W-1:0] cfg_pixel_bytes;

    task automatic report_mismatch(input string what);
        // cap the log, keep counting
        if (err_count < 200)
            $display("%0t ns: mismatch: %s", $time, what);
        err_count++;
    endtask

    task automatic new_row();
        left_bytes  = '0;
        upper_bytes = '0;
        column      = 0;
        want_code   = 1'b1;
    endtask

    task automatic rebuild_byte(input logic [7:0] x, input logic start);
        int unsigned step_back;
        int unsigned len;
        int          p;
        int          pa;
        int          pb;
        int          pc;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  pred;
        logic [7:0]  res;
        logic        last;
        if (start)
        begin
            new_row();
            in_first_row = 1'b1;
        end
        if (want_code)
        begin
            row_filter = (x <= 8'd4) ? filter_t'(x[2:0]) : FLT_NONE;
            want_code  = 1'b0;
            return;
        end

        step_back = (cfg_pixel_bytes == 0) ? 1 :
                    (cfg_pixel_bytes > DEF_MAX_PIXEL_BYTES) ? DEF_MAX_PIXEL_BYTES :
                    cfg_pixel_bytes;
        a = left_bytes[8*(step_back-1) +: 8];
        c = upper_bytes[8*(step_back-1) +: 8];
        b = in_first_row ? 8'h00 : prev_row[column % DEF_MAX_ROW_BYTES];

        case (row_filter)
            FLT_SUB:   pred = a;
            FLT_UP:    pred = b;
            FLT_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
            FLT_PAETH:
            begin
                p  = int'(a) + int'(b) - int'(c);
                pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
                pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
                pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
                if (pa <= pb && pa <= pc)
                    pred = a;
                else if (pb <= pc)
                    pred = b;
                else
                    pred = c;
            end
            default:   pred = 8'h00;
        endcase
        res = x + pred;

        prev_row[column % DEF_MAX_ROW_BYTES] = res;
        left_bytes  = {left_bytes[55:0], res};
        upper_bytes = {upper_bytes[55:0], b};

        len = (cfg_rows == 0) ? 1 :
              (cfg_rows > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES : cfg_rows;
        last = (column + 1 >= len);
        if (last)
        begin
            new_row();
            in_first_row = 1'b0;
        end
        else
        begin
            column++;
        end
        expected_pixels.push_back('{pixel: res, last: last});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_pixels.delete();
            new_row();
            row_filter      = FLT_NONE;
            in_first_row    = 1'b1;
            cfg_rows        = 1;
            cfg_pixel_bytes = 1;
            err_count       = 0;
            mismatches     <= 0;
            expected_count <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("result word %02h/%0b with none expected",
                                              pixel_byte, row_end));
                end
                else
                begin
                    oldest = expected_pixels.pop_front();
                    if (pixel_byte !== oldest.pixel)
                        report_mismatch($sformatf("pixel_byte %02h, expected %02h",
                                                  pixel_byte, oldest.pixel));
                    if (row_end !== oldest.last)
                        report_mismatch($sformatf("row_end %0b, expected %0b",
                                                  row_end, oldest.last));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROW_BYTES:   cfg_rows        = cfg_data[ROW_BYTES_W-1:0];
                    REG_PIXEL_BYTES: cfg_pixel_bytes = cfg_data[PIXEL_BYTES_W-1:0];
                    default: ;
                endcase
            end
            if (push && !full)
                rebuild_byte(data_byte, image_start);
            mismatches     <= err_count;
            expected_count <= expected_pixels.size();
        end
    end

endmodule

@@ sim/png_scanline_unfilter_core_tb.sv @@
// Testbench top for the PNG scanline unfilter core: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps

module png_scanline_unfilter_core_tb;
    import png_unf_pkg::*;

    localparam int RANDOM_ITEMS = 1700;

    // rows of four bytes: every filter, an unknown code, byte extremes
    localparam logic [0:29][7:0] DIRECTED_ROWS = {
        8'(FLT_NONE),  8'h00, 8'hFF, 8'h80, 8'h7F,
        8'(FLT_SUB),   8'hFF, 8'h01, 8'h80, 8'h80,
        8'(FLT_UP),    8'h01, 8'hFF, 8'h00, 8'h80,
        8'(FLT_AVG),   8'hFF, 8'hFF, 8'h01, 8'h00,
        8'(FLT_PAETH), 8'h10, 8'hF0, 8'h80, 8'h7F,
        8'd7,          8'hAA, 8'h55, 8'h00, 8'hFF
    };

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [7:0]             data_byte;
    logic                   image_start;
    logic                   empty;
    logic                   pop;
    logic [7:0]             pixel_byte;
    logic                   row_end;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     expected_count;

    int                     items_sent;
    int                     row_len;
    bit                     quiet;

    png_scanline_unfilter_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .image_start (image_start),
        .empty       (empty),
        .pop         (pop),
        .pixel_byte  (pixel_byte),
        .row_end     (row_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    png_unfilter_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .image_start    (image_start),
        .empty          (empty),
        .pop            (pop),
        .pixel_byte     (pixel_byte),
        .row_end        (row_end),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .expected_count (expected_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side stalls at random
    always @(posedge clk)
        pop <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 35);

    initial
    begin
        #20_000_000;
        $display("png_scanline_unfilter_core test failed");
        $finish;
    end

    function automatic logic [7:0] random_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80 ^ 8'($urandom_range(0, 3));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        if ($urandom_range(0, 9) < 8)
            return 8'($urandom_range(0, 4));
        return 8'($urandom_range(5, 255));
    endfunction

    task automatic send_word(input logic [7:0] value, input logic start);
        if (!quiet && $urandom_range(0, 99) < 35)
        begin
            push <= 1'b0;
            do
                @(posedge clk);
            while (!quiet && $urandom_range(0, 99) < 35);
        end
        push        <= 1'b1;
        data_byte   <= value;
        image_start <= start;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_row(input logic [7:0] code, input logic start, input int len);
        send_word(code, start);
        for (int i = 0; i < len; i++)
            send_word(random_data(), 1'b0);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input int rows, input int pixel_bytes, input bit set_pixel);
        push <= 1'b0;
        do
            @(posedge clk);
        while (expected_count != 0);
        // a trailing code word may still be in flight
        repeat (8) @(posedge clk);
        cfg_write(REG_ROW_BYTES, rows);
        if (set_pixel)
            cfg_write(REG_PIXEL_BYTES, pixel_bytes);
        cfg_valid <= 1'b0;
        row_len = (rows == 0) ? 1 : (rows > DEF_MAX_ROW_BYTES) ? DEF_MAX_ROW_BYTES : rows;
    endtask

    initial
    begin
        int rand_base;
        int rows;
        int pixel_bytes;
        int pick;
        int wait_cycles;
        int rows_in_image;
        clk         = 1'b0;
        rst_n       = 1'b0;
        push        = 1'b0;
        data_byte   = 8'h00;
        image_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_ROW_BYTES;
        cfg_data    = '0;
        quiet       = 1'b0;
        items_sent  = 0;
        row_len     = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte rows at the reset settings
        send_word(8'(FLT_SUB), 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'(FLT_UP), 1'b0);
        send_word(8'h01, 1'b0);

        program_regs(4, 2, 1'b1);
        for (int i = 0; i < 30; i++)
            send_word(DIRECTED_ROWS[i], i == 0);

        // shrink the row while two bytes in: the next byte ends it
        send_word(8'(FLT_PAETH), 1'b0);
        send_word(8'h33, 1'b0);
        send_word(8'hC4, 1'b0);
        program_regs(2, 3, 1'b1);
        send_word(8'h5A, 1'b0);
        send_word(8'(FLT_AVG), 1'b0);
        send_word(8'hE1, 1'b0);
        send_word(8'h1E, 1'b0);

        // drop a row in progress with a new image, then grow the first row
        send_word(8'(FLT_SUB), 1'b0);
        send_word(8'h77, 1'b0);
        send_word(8'(FLT_UP), 1'b1);
        send_word(8'h12, 1'b0);
        program_regs(6, 8, 1'b1);
        for (int i = 0; i < 5; i++)
            send_word(random_data(), 1'b0);
        send_row(8'(FLT_PAETH), 1'b0, 6);

        rand_base = items_sent;
        while (items_sent - rand_base < RANDOM_ITEMS)
        begin
            quiet = (items_sent - rand_base >= 700) && (items_sent - rand_base < 1000);
            pick = $urandom_range(0, 99);
            if (pick < 8)
                rows = 0;
            else if (pick < 85)
                rows = $urandom_range(1, 12);
            else
                rows = $urandom_range(13, 48);
            pixel_bytes = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8)
                                                       : $urandom_range(0, 15);
            program_regs(rows, pixel_bytes, $urandom_range(0, 3) != 0);
            for (int img = $urandom_range(1, 3); img > 0; img--)
            begin
                // each image opens with a first row that fills the line store
                rows_in_image = $urandom_range(1, 4);
                for (int r = rows_in_image; r > 0; r--)
                    send_row(pick_code(), r == rows_in_image, row_len);
                if (img != 1 && $urandom_range(0, 99) < 15)
                begin
                    // noise: stray words, some restarting the image
                    for (int n = $urandom_range(1, 6); n > 0; n--)
                        send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
        end
        quiet = 1'b0;

        // a long row once, then part of a row that reads it back
        program_regs($urandom_range(100, 250), $urandom_range(0, 15), 1'b1);
        send_row(pick_code(), 1'b1, row_len);
        send_row(8'($urandom_range(1, 4)), 1'b0, $urandom_range(1, 30));

        push <= 1'b0;
        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (expected_count != 0 && wait_cycles < 20000);
        repeat (16) @(posedge clk);
        if (mismatches == 0 && expected_count == 0)
            $display("png_scanline_unfilter_core test passed");
        else
            $display("png_scanline_unfilter_core test failed");
        $finish;
    end

endmodule
